@@ rtl/eet_pkg.sv @@
package eet_pkg;

   localparam int TIME_W = 64;
   localparam int PID_W  = 32;
   localparam int CALL_W = 10;
   localparam int ERR_W  = 12;
   localparam int KEY_W  = PID_W + CALL_W + ERR_W;
   localparam int CNT_W  = 32;
   localparam int BCNT_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_IGNORED    = 2'd0,
      ACT_SUPPRESSED = 2'd1,
      ACT_REPORTED   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SEV_CRITICAL = 2'd0,
      SEV_HIGH     = 2'd1,
      SEV_MEDIUM   = 2'd2,
      SEV_LOW      = 2'd3
   } severity_type;

   typedef enum logic [2:0] {
      CAT_FILE    = 3'd0,
      CAT_NETWORK = 3'd1,
      CAT_MEMORY  = 3'd2,
      CAT_PROCESS = 3'd3,
      CAT_OTHER   = 3'd4
   } category_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_CRITICAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_HIGH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_MEDIUM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LOW      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_WINDOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_ALLOWANCE   = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_ns;
      logic [PID_W-1:0]  process_id;
      logic [CALL_W-1:0] call_number;
      logic [ERR_W-1:0]  error_number;
   } req_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [2:0]        category;
      logic [1:0]        severity;
      logic [CNT_W-1:0]  occurrences;
      logic [TIME_W-1:0] echo_time;
      logic [PID_W-1:0]  echo_process;
      logic [CALL_W-1:0] echo_call;
      logic [ERR_W-1:0]  echo_error;
   } rsp_type;

   // Per-slot record held in the slot memory.
   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] last_time;
      logic [TIME_W-1:0] win_start;
      logic [BCNT_W-1:0] win_count;
   } slot_type;

   // tracked: severity valid flag in bit 2 (1 = not tracked)
   function automatic logic [2:0] severity_of(input logic [ERR_W-1:0] e);
      case (e)
         12'd12, 12'd28, 12'd122: severity_of = {1'b0, SEV_CRITICAL};
         12'd5, 12'd24, 12'd111:  severity_of = {1'b0, SEV_HIGH};
         12'd1, 12'd13, 12'd110:  severity_of = {1'b0, SEV_MEDIUM};
         default:                 severity_of = 3'b100;
      endcase
   endfunction

   function automatic category_type category_of(input logic [CALL_W-1:0] c);
      case (c)
         10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd8, 10'd9,
         10'd16, 10'd17, 10'd18, 10'd19, 10'd20, 10'd21,
         10'd74, 10'd75, 10'd76, 10'd77,
         10'd257, 10'd258, 10'd259, 10'd260, 10'd262, 10'd263:
            category_of = CAT_FILE;
         10'd41, 10'd42, 10'd43, 10'd44, 10'd45, 10'd46, 10'd47, 10'd48,
         10'd49, 10'd50, 10'd51, 10'd52, 10'd53, 10'd54, 10'd288:
            category_of = CAT_NETWORK;
         10'd10, 10'd11, 10'd12, 10'd25, 10'd26, 10'd27, 10'd28:
            category_of = CAT_MEMORY;
         10'd56, 10'd57, 10'd58, 10'd59, 10'd60, 10'd61, 10'd62, 10'd247:
            category_of = CAT_PROCESS;
         default:
            category_of = CAT_OTHER;
      endcase
   endfunction

endpackage

@@ rtl/eet_stream_if.sv @@
interface eet_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/error_event_throttle.sv @@
// error_event_throttle: rate limiter for error events at system call exit.
//
// req channel: one transaction per exit event (time, process, call, error).
// rsp channel: exactly one result transaction per request: ignored,
// suppressed (with the running repeat count) or reported (with the count of
// repeats since the last report). csr port: write-only settings, index 0..5
// (intervals per severity, burst window, burst allowance).
//
// A request is accepted in the idle state; the key match and slot memory
// read are done in the lookup state, and the modify, write back and result
// load in the update state. One event is in flight at a time: the next
// request is taken only once the block is back in the idle state. The
// result register holds a single result: while it waits, req.ready stays
// low unless the receiver takes the result in that same cycle, so a stalled
// receiver blocks the input at once.
//
// Reset clears the valid bits, sets LRU ages to slot order and loads the
// default settings; the slot record memory is not cleared, since the record
// of an invalid slot is never used.
module error_event_throttle #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   eet_stream_if.sink                 req,
   eet_stream_if.source               rsp,
   input  logic                       csr_write,
   input  logic [eet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [eet_pkg::CSR_DATA_W-1:0] csr_data
);
   import eet_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   state_type state_ff, state_in;
   req_type   ev_ff, ev_in;
   logic [2:0] sev_ff, sev_in;
   logic       hit_ff;
   logic [IDX_W-1:0] slot_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [31:0] ivl_crit_ff, ivl_high_ff, ivl_med_ff, ivl_low_ff, window_ff;
   logic [7:0]  allow_ff;

   logic             hit;
   logic [IDX_W-1:0] slot;
   logic             touch;
   slot_type         rd_rec, wr_rec;
   logic             wr_en;
   logic [KEY_W-1:0] key;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_crit_ff <= 32'd50000000;
         ivl_high_ff <= 32'd75000000;
         ivl_med_ff  <= 32'd100000000;
         ivl_low_ff  <= 32'd200000000;
         window_ff   <= 32'd1000000000;
         allow_ff    <= 8'd5;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INTERVAL_CRITICAL: ivl_crit_ff <= csr_data;
            CSR_INTERVAL_HIGH:     ivl_high_ff <= csr_data;
            CSR_INTERVAL_MEDIUM:   ivl_med_ff  <= csr_data;
            CSR_INTERVAL_LOW:      ivl_low_ff  <= csr_data;
            CSR_BURST_WINDOW:      window_ff   <= csr_data;
            CSR_BURST_ALLOWANCE:   allow_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign key = {ev_ff.process_id, ev_ff.call_number, ev_ff.error_number};
   // take a request only when the result register is free or being drained
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // table is touched in the lookup cycle for tracked errors
   assign touch = (state_ff == ST_LOOKUP) && !sev_ff[2];

   eet_match #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_match (
      .clock, .reset, .key, .hit, .slot, .touch
   );

   eet_slot_ram #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_ram (
      .clock, .wr_en, .wr_addr(slot_ff), .wr_data(wr_rec),
      .rd_addr(slot), .rd_data(rd_rec)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req.valid && req.ready) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [TIME_W-1:0] since, bspan;
      logic [CNT_W-1:0]  cnt_inc;
      logic [BCNT_W-1:0] bc_inc;
      logic [31:0]       ivl;
      logic              suppress;
      ev_in = ev_ff;
      sev_in = sev_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      wr_en = 1'b0;
      wr_rec = rd_rec;
      since = ev_ff.time_ns - rd_rec.last_time;
      bspan = ev_ff.time_ns - rd_rec.win_start;
      cnt_inc = (rd_rec.count == '1) ? rd_rec.count : rd_rec.count + 1'b1;
      bc_inc = (rd_rec.win_count == '1) ? rd_rec.win_count
                                        : rd_rec.win_count + 1'b1;
      suppress = 1'b0;
      case (sev_ff[1:0])
         SEV_CRITICAL: ivl = ivl_crit_ff;
         SEV_HIGH:     ivl = ivl_high_ff;
         SEV_MEDIUM:   ivl = ivl_med_ff;
         default:      ivl = ivl_low_ff;
      endcase
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               ev_in = req.payload;
               sev_in = severity_of(req.payload.error_number);
            end
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_in.echo_time = ev_ff.time_ns;
            rsp_in.echo_process = ev_ff.process_id;
            rsp_in.echo_call = ev_ff.call_number;
            rsp_in.echo_error = ev_ff.error_number;
            rsp_in.action = ACT_IGNORED;
            rsp_in.category = CAT_FILE;
            rsp_in.severity = SEV_CRITICAL;
            rsp_in.occurrences = '0;
            if (!sev_ff[2]) begin
               wr_en = 1'b1;
               rsp_in.category = category_of(ev_ff.call_number);
               rsp_in.severity = sev_ff[1:0];
               rsp_in.action = ACT_REPORTED;
               if (!hit_ff) begin
                  // insert fresh key
                  wr_rec.count = CNT_W'(1);
                  wr_rec.last_time = ev_ff.time_ns;
                  wr_rec.win_start = ev_ff.time_ns;
                  wr_rec.win_count = BCNT_W'(1);
                  rsp_in.occurrences = CNT_W'(1);
               end else begin
                  if (sev_ff[1:0] == SEV_CRITICAL) begin
                     if (bspan > TIME_W'(window_ff)) begin
                        wr_rec.win_start = ev_ff.time_ns;
                        wr_rec.win_count = BCNT_W'(1);
                     end else begin
                        wr_rec.win_count = bc_inc;
                        suppress = (bc_inc > BCNT_W'(allow_ff)) &&
                                   (since < TIME_W'(ivl));
                     end
                  end else begin
                     suppress = since < TIME_W'(ivl);
                  end
                  wr_rec.last_time = ev_ff.time_ns;
                  if (suppress) begin
                     wr_rec.count = cnt_inc;
                     rsp_in.action = ACT_SUPPRESSED;
                     rsp_in.occurrences = cnt_inc;
                  end else begin
                     wr_rec.count = CNT_W'(1);
                     rsp_in.occurrences = rd_rec.count;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the event and lookup outcome across the memory read
   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
      sev_ff <= sev_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_LOOKUP) begin
         hit_ff <= hit;
         slot_ff <= slot;
      end
   end
endmodule

@@ rtl/eet_match.sv @@
// Key directory: valid bits, keys and LRU ages per slot. Matches one key
// against all slots, picks the victim and reorders ages on touch.
module eet_match #(
   parameter int TABLE_ENTRIES = 64,
   parameter int IDX_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [eet_pkg::KEY_W-1:0]   key,
   output logic                        hit,
   output logic [IDX_W-1:0]            slot,
   input  logic                        touch
);
   import eet_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]         key_ff [TABLE_ENTRIES];
   logic [IDX_W-1:0]         age_ff [TABLE_ENTRIES];
   logic [IDX_W-1:0]         age_in [TABLE_ENTRIES];
   logic [IDX_W-1:0]         hit_idx, free_idx, old_idx, touch_age;
   logic                     any_free;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      any_free = 1'b0;
      free_idx = '0;
      old_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == key) begin
            hit = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (age_ff[i] == IDX_W'(TABLE_ENTRIES - 1)) begin
            old_idx = IDX_W'(i);
         end
      end
      slot = hit ? hit_idx : (any_free ? free_idx : old_idx);
   end

   always_comb begin
      touch_age = age_ff[slot];
      valid_in = valid_ff;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (touch) begin
            if (IDX_W'(i) == slot) begin
               age_in[i] = '0;
            end else if (age_ff[i] < touch_age) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
      end
      if (touch) begin
         valid_in[slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            age_ff[i] <= IDX_W'(i);
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (touch && !hit) begin
         key_ff[slot] <= key;
      end
   end
endmodule

@@ rtl/eet_slot_ram.sv @@
// Slot record memory: one write port, one read port, registered read.
module eet_slot_ram #(
   parameter int TABLE_ENTRIES = 64,
   parameter int IDX_W = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  eet_pkg::slot_type      wr_data,
   input  logic [IDX_W-1:0]       rd_addr,
   output eet_pkg::slot_type      rd_data
);
   import eet_pkg::*;

   slot_type mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/eet_checker.sv @@
module eet_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_action,
   input logic [1:0] rsp_severity,
   input logic [31:0] rsp_occurrences
);
   import eet_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_action) && $stable(rsp_occurrences))
      else $error("result changed while stalled");

   a_no_early_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_report_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_REPORTED |-> rsp_occurrences != '0)
      else $error("report with zero count");

   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_IGNORED |-> rsp_occurrences == '0
         && rsp_severity == SEV_CRITICAL)
      else $error("ignored result carries data");
endmodule

bind error_event_throttle eet_checker u_eet_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_action(rsp.payload.action),
   .rsp_severity(rsp.payload.severity),
   .rsp_occurrences(rsp.payload.occurrences)
);
